>>> src/ipsc_pkg.sv
// Shared types, widths and register codes of the incremental PI speed controller.
`default_nettype none
package ipsc_pkg;

  // Fraction bits of the Q-format gains and of the drive accumulator
  localparam int GAIN_FRAC_BITS = 8;

  localparam int CFG_W    = 16;
  localparam int SP_W     = 13;
  localparam int SPD_W    = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 16;
  localparam int CFG_IDX_W = 2;

  // measured-speed map: (speed - 50) * 10 + 1200
  localparam int MAP_OFFSET = 50;
  localparam int MAP_BASE   = 1200;
  localparam int MAP_W      = SPD_W + 5;

  localparam int ISEP_LIMIT = 5500;
  localparam int NEAR_LIMIT = 10;

  // target = (setpoint * base_rate) >> F
  localparam int TGT_W  = SP_W + CFG_W - GAIN_FRAC_BITS;
  // error span: target plus mapped range, with sign
  localparam int ERR_W  = ((TGT_W > MAP_W - 1) ? TGT_W : MAP_W - 1) + 2;
  localparam int DIFF_W = ERR_W + 1;

  // shared multiplier: unsigned 16-bit gain times signed operand
  localparam int MUL_A_W = CFG_W + 1;
  localparam int MUL_B_W = DIFF_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int ACC_W = DATA_W + GAIN_FRAC_BITS;
  localparam int SUM_W = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX = 2'd3;

  localparam logic [CFG_W-1:0]  BASE_RATE_RST  = 16'd256;
  localparam logic [DATA_W-1:0] OUTPUT_MAX_RST = 32'd720;

  typedef enum logic [1:0] {
    MUL_TGT = 2'd0,
    MUL_P   = 2'd1,
    MUL_I   = 2'd2
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load_in;   // capture input transfer
    logic     prod_en;   // register multiplier result
    mul_sel_t mul_sel;
    logic     err_en;    // register error
    logic     sum_en;    // accumulator + proportional term
    logic     commit;    // update state and output registers
  } ipsc_cmd_t;

endpackage
`default_nettype wire

>>> src/ipsc_ctrl.sv
// Sequencer of the speed controller: steps one tick through the shared multiplier.
`default_nettype none
module ipsc_ctrl import ipsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output ipsc_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_TGT    = 6'b000010,
    ST_ERR    = 6'b000100,
    ST_PMUL   = 6'b001000,
    ST_IMUL   = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_TGT;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_TGT;
        end
      end
      ST_TGT: begin
        cmd.prod_en = 1'b1;
        cmd.mul_sel = MUL_TGT;
        state_nxt   = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
        state_nxt  = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.prod_en = 1'b1;
        cmd.mul_sel = MUL_P;
        state_nxt   = ST_IMUL;
      end
      ST_IMUL: begin
        cmd.sum_en  = 1'b1;
        cmd.prod_en = 1'b1;
        cmd.mul_sel = MUL_I;
        state_nxt   = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result not presented after commit");

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("commit overwrote a pending result");

  a_tgt_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TGT) |-> $past(in_valid && !in_stall))
    else $error("sequence started without an input transfer");

endmodule
`default_nettype wire

>>> src/ipsc_dp.sv
// Datapath of the speed controller: config registers, shared multiplier, accumulator.
`default_nettype none
module ipsc_dp import ipsc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ipsc_cmd_t            cmd,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  input  wire logic [SP_W-1:0]      in_expected_speed,
  input  wire logic signed [SPD_W-1:0] in_filtered_speed,
  input  wire logic                 in_running,
  output logic signed [DATA_W-1:0]  out_drive_out,
  output logic signed [DATA_W-1:0]  out_speed_error,
  output logic [CNT_W-1:0]          out_near_target_count
);

  logic [CFG_W-1:0]         base_rate_r, p_gain_r, i_gain_r;
  logic signed [DATA_W-1:0] output_max_r;

  logic [SP_W-1:0]          sp_r;
  logic signed [SPD_W-1:0]  spd_r;
  logic                     run_r;

  logic signed [ERR_W-1:0]  err_r, prev_err_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [CNT_W-1:0]         near_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;

  logic signed [DATA_W-1:0] drive_r, serr_r;
  logic [CNT_W-1:0]         near_out_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_rate_r  <= BASE_RATE_RST;
      p_gain_r     <= '0;
      i_gain_r     <= '0;
      output_max_r <= OUTPUT_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_RATE:  base_rate_r  <= cfg_data[CFG_W-1:0];
        REG_P_GAIN:     p_gain_r     <= cfg_data[CFG_W-1:0];
        REG_I_GAIN:     i_gain_r     <= cfg_data[CFG_W-1:0];
        REG_OUTPUT_MAX: output_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sp_r  <= in_expected_speed;
      spd_r <= in_filtered_speed;
      run_r <= in_running;
    end
  end

  // measured speed map: (s - 50) * 10 + 1200, times ten as shift-add
  logic signed [MAP_W-1:0] map_off, map_s;
  logic [TGT_W-1:0]        tgt;
  logic signed [ERR_W-1:0] err_nxt;

  assign map_off = MAP_W'(spd_r) - MAP_W'(MAP_OFFSET);
  assign map_s   = (map_off <<< 3) + (map_off <<< 1) + MAP_W'(MAP_BASE);
  assign tgt     = prod_r[GAIN_FRAC_BITS +: TGT_W];
  assign err_nxt = $signed(ERR_W'(tgt)) - ERR_W'(map_s);

  // integral separation and near-target window
  logic isep_ok, near_ok;
  assign isep_ok = run_r && (err_r <= ERR_W'(ISEP_LIMIT)) && (err_r >= -ERR_W'(ISEP_LIMIT));
  assign near_ok = run_r && (err_r <= ERR_W'(NEAR_LIMIT)) && (err_r >= -ERR_W'(NEAR_LIMIT));

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = $signed({1'b0, p_gain_r});
        mul_b = MUL_B_W'(err_r) - MUL_B_W'(prev_err_r);
      end
      MUL_I: begin
        mul_a = isep_ok ? $signed({1'b0, i_gain_r}) : '0;
        mul_b = MUL_B_W'(err_r);
      end
      default: begin
        mul_a = $signed({1'b0, base_rate_r});
        mul_b = $signed(MUL_B_W'(sp_r));
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.prod_en) prod_r <= mul_p;
    if (cmd.err_en)  err_r  <= err_nxt;
    if (cmd.sum_en)  sum_r  <= SUM_W'(acc_r) + SUM_W'(prod_r);
  end

  // final add, upper clamp first, then lower saturation
  logic signed [ACC_W-1:0] hi_a, lo_a, acc_nxt;
  logic signed [SUM_W-1:0] tot;

  assign hi_a = {output_max_r, {GAIN_FRAC_BITS{1'b0}}};
  assign lo_a = {1'b1, {(ACC_W-1){1'b0}}};
  assign tot  = sum_r + SUM_W'(prod_r);

  always_comb begin
    if (tot >= SUM_W'(hi_a)) begin
      acc_nxt = hi_a;
    end else if (tot < SUM_W'(lo_a)) begin
      acc_nxt = lo_a;
    end else begin
      acc_nxt = tot[ACC_W-1:0];
    end
  end

  logic [CNT_W-1:0] near_nxt;
  assign near_nxt = (near_ok && (near_r != {CNT_W{1'b1}})) ? near_r + 1'b1 : near_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      prev_err_r <= '0;
      near_r     <= '0;
    end else if (cmd.commit) begin
      acc_r      <= acc_nxt;
      prev_err_r <= err_r;
      near_r     <= near_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      drive_r    <= acc_nxt[ACC_W-1:GAIN_FRAC_BITS];
      serr_r     <= DATA_W'(err_r);
      near_out_r <= near_nxt;
    end
  end

  assign out_drive_out         = drive_r;
  assign out_speed_error       = serr_r;
  assign out_near_target_count = near_out_r;

endmodule
`default_nettype wire

>>> src/incremental_pi_speed_controller.sv
// Incremental PI speed controller with integral separation (top level).
// Sequence from input transfer to result valid: target multiply, error, P multiply,
//   I multiply, clamp and commit; one tick in flight at a time.
// The single multiplier is used three times per tick; a waiting result is held in the
//   output register while the next tick is taken.
// Reset (rst_n low, synchronous): base_rate=256, gains 0, output_max=720; state cleared.
`default_nettype none
module incremental_pi_speed_controller import ipsc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input tick channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [SP_W-1:0]          in_expected_speed,
  input  wire logic signed [SPD_W-1:0]  in_filtered_speed,
  input  wire logic                     in_running,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_drive_out,
  output logic signed [DATA_W-1:0]      out_speed_error,
  output logic [CNT_W-1:0]              out_near_target_count,
  // configuration write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data
);

  ipsc_cmd_t cmd;

  // config writes must be issued only while the block is idle; the block does not check
  assign cfg_ready = 1'b1;

  ipsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ipsc_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_expected_speed     (in_expected_speed),
    .in_filtered_speed     (in_filtered_speed),
    .in_running            (in_running),
    .out_drive_out         (out_drive_out),
    .out_speed_error       (out_speed_error),
    .out_near_target_count (out_near_target_count)
  );

endmodule
`default_nettype wire
